/* hdl/hbk_pkg.sv */
// Shared constants, lookup tables and helpers for the boot-keyboard to set-1 converter.
package hbk_pkg;

  // Report geometry
  localparam int NUM_SLOTS      = 6;
  localparam int NUM_MODS       = 8;
  localparam int USAGE_MAP_SIZE = 89;
  localparam int REPORT_LEN     = 8;

  // Item modes
  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_ATTACH = 2'd1;
  localparam logic [1:0] MODE_DETACH = 2'd2;

  // Lowest usage that names a real key
  localparam logic [7:0] FIRST_KEY_USAGE = 8'd4;

  // Step counter wide enough for the eight modifier bits
  typedef logic [2:0] step_idx_t;

  // Packed key code: bit 7 extended prefix, bits 6:0 scan code, zero means no mapping
  typedef logic [7:0] key_code_t;

  localparam key_code_t USAGE_MAP [USAGE_MAP_SIZE] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
    8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
    8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
    8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
    8'h1B, 8'h2B, 8'h00, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
    8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h00,
    8'h00, 8'hD2, 8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1, 8'hCD,
    8'hCB, 8'hD0, 8'hC8, 8'h45, 8'hB5, 8'h37, 8'h4A, 8'h4E,
    8'h9C
  };

  localparam key_code_t MOD_MAP [NUM_MODS] = '{
    8'h1D, 8'h2A, 8'h38, 8'h00, 8'h9D, 8'h36, 8'hB8, 8'h00
  };

  // Translate a HID usage; anything beyond the table has no mapping
  function automatic key_code_t map_usage(input logic [7:0] usage);
    key_code_t code;
    code = 8'h00;
    if (usage < 8'(USAGE_MAP_SIZE)) begin
      code = USAGE_MAP[usage[6:0]];
    end
    return code;
  endfunction

endpackage

/* hdl/hid_boot_keyboard_to_scancode_core.sv */
// Top level: boot-keyboard report to set-1 scan code event sequencer.
// The block takes one item (report, attach or detach) at a time and answers it with zero or more
// key events followed by exactly one status result flagged last. A single compare-and-lookup unit
// is stepped by a small sequencer over the six held slots, the eight modifier bits and the six new
// slots for an accepted report, or over the eight modifier bits and the six held slots for a
// matching detach, one position per cycle while no key event waits on out_stall. in_stall stays
// high after an item is taken until its status result is written to the output register.
// Results leave through a single output register, so the next item may be taken while the status
// of the previous one still waits on out_stall.
module hid_boot_keyboard_to_scancode_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_generation,
  input  logic [7:0]  in_report_length,
  input  logic [7:0]  in_modifier_bits,
  input  logic [7:0]  in_reserved_byte,
  input  logic [7:0]  in_key_slot_0,
  input  logic [7:0]  in_key_slot_1,
  input  logic [7:0]  in_key_slot_2,
  input  logic [7:0]  in_key_slot_3,
  input  logic [7:0]  in_key_slot_4,
  input  logic [7:0]  in_key_slot_5,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_event,
  output logic [6:0]  out_scan_code,
  output logic        out_extended,
  output logic        out_released,
  output logic        out_accepted,
  output logic        out_last
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_REL    = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_PRS    = 3'd4;
  localparam logic [2:0] ST_DMOD   = 3'd5;
  localparam logic [2:0] ST_DKEY   = 3'd6;
  localparam logic [2:0] ST_STATUS = 3'd7;

  localparam hbk_pkg::step_idx_t LAST_SLOT = hbk_pkg::step_idx_t'(hbk_pkg::NUM_SLOTS - 1);
  localparam hbk_pkg::step_idx_t LAST_MOD  = hbk_pkg::step_idx_t'(hbk_pkg::NUM_MODS - 1);

  // Control state
  logic [2:0]          state_r, state_nxt;
  hbk_pkg::step_idx_t  idx_r, idx_nxt;
  logic                acc_r, acc_nxt;

  // Captured item
  logic [1:0]          mode_r;
  logic [31:0]         gen_r;
  logic [7:0]          len_r;
  logic [7:0]          mods_in_r;
  logic [7:0]          resv_r;
  logic [7:0]          slot_in_r [hbk_pkg::NUM_SLOTS];

  // Keyboard history
  logic [7:0]          held_mod_r, held_mod_nxt;
  logic [7:0]          held_key_r [hbk_pkg::NUM_SLOTS];
  logic [7:0]          held_key_nxt [hbk_pkg::NUM_SLOTS];
  logic [31:0]         cur_gen_r, cur_gen_nxt;
  logic                attached_r, attached_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_is_event_r, out_is_event_nxt;
  hbk_pkg::key_code_t  out_key_r, out_key_nxt;
  logic                out_released_r, out_released_nxt;
  logic                out_accepted_r, out_accepted_nxt;
  logic                out_last_r, out_last_nxt;

  // Step unit signals
  logic                in_take;
  logic                out_free;
  logic [7:0]          probe;
  logic                member;
  hbk_pkg::key_code_t  cand_key;
  logic                cand_hit;
  logic                cand_rel;
  logic                emit;
  logic                last_step;
  logic                report_ok;
  logic                low_usage;
  logic                held_low_usage;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Capture the item on acceptance
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r       <= in_mode;
      gen_r        <= in_generation;
      len_r        <= in_report_length;
      mods_in_r    <= in_modifier_bits;
      resv_r       <= in_reserved_byte;
      slot_in_r[0] <= in_key_slot_0;
      slot_in_r[1] <= in_key_slot_1;
      slot_in_r[2] <= in_key_slot_2;
      slot_in_r[3] <= in_key_slot_3;
      slot_in_r[4] <= in_key_slot_4;
      slot_in_r[5] <= in_key_slot_5;
    end
  end

  // Flag any new slot, and separately any held slot, holding one of the error usages
  always_comb begin
    low_usage      = 1'b0;
    held_low_usage = 1'b0;
    for (int i = 0; i < hbk_pkg::NUM_SLOTS; i++) begin
      if (slot_in_r[i] != 8'h00 && slot_in_r[i] < hbk_pkg::FIRST_KEY_USAGE) begin
        low_usage = 1'b1;
      end
      if (held_key_r[i] != 8'h00 && held_key_r[i] < hbk_pkg::FIRST_KEY_USAGE) begin
        held_low_usage = 1'b1;
      end
    end
  end

  assign report_ok = attached_r && (gen_r == cur_gen_r) &&
                     (len_r == 8'(hbk_pkg::REPORT_LEN)) && (resv_r == 8'h00) && !low_usage;

  // Shared step unit: pick a probe, test it against the other slot set, look up its code
  always_comb begin
    probe = 8'h00;
    unique case (state_r)
      ST_REL, ST_DKEY: probe = held_key_r[idx_r];
      ST_PRS:          probe = slot_in_r[idx_r];
      default:         probe = 8'h00;
    endcase

    member = 1'b0;
    for (int i = 0; i < hbk_pkg::NUM_SLOTS; i++) begin
      if (state_r == ST_REL && slot_in_r[i] == probe) begin
        member = 1'b1;
      end
      if (state_r == ST_PRS && held_key_r[i] == probe) begin
        member = 1'b1;
      end
    end

    cand_key  = hbk_pkg::map_usage(probe);
    cand_hit  = 1'b0;
    cand_rel  = 1'b1;
    last_step = (idx_r == LAST_SLOT);
    unique case (state_r)
      ST_REL: begin
        cand_hit = (probe >= hbk_pkg::FIRST_KEY_USAGE) && !member;
      end
      ST_MOD: begin
        cand_key  = hbk_pkg::MOD_MAP[idx_r];
        cand_hit  = held_mod_r[idx_r] ^ mods_in_r[idx_r];
        cand_rel  = !mods_in_r[idx_r];
        last_step = (idx_r == LAST_MOD);
      end
      ST_PRS: begin
        cand_hit = (probe >= hbk_pkg::FIRST_KEY_USAGE) && !member;
        cand_rel = 1'b0;
      end
      ST_DMOD: begin
        cand_key  = hbk_pkg::MOD_MAP[idx_r];
        cand_hit  = held_mod_r[idx_r];
        last_step = (idx_r == LAST_MOD);
      end
      ST_DKEY: begin
        cand_hit = (probe >= hbk_pkg::FIRST_KEY_USAGE);
      end
      default: begin
        cand_hit = 1'b0;
      end
    endcase
    emit = cand_hit && (cand_key[6:0] != 7'd0);
  end

  // Sequencer and history update
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    acc_nxt          = acc_r;
    held_mod_nxt     = held_mod_r;
    held_key_nxt     = held_key_r;
    cur_gen_nxt      = cur_gen_r;
    attached_nxt     = attached_r;
    out_is_event_nxt = out_is_event_r;
    out_key_nxt      = out_key_r;
    out_released_nxt = out_released_r;
    out_accepted_nxt = out_accepted_r;
    out_last_nxt     = out_last_r;
    out_valid_nxt    = out_stall ? out_valid_r : 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_CHECK;
          idx_nxt   = '0;
        end
      end

      ST_CHECK: begin
        acc_nxt   = 1'b0;
        state_nxt = ST_STATUS;
        unique case (mode_r)
          hbk_pkg::MODE_ATTACH: begin
            held_mod_nxt = 8'h00;
            for (int i = 0; i < hbk_pkg::NUM_SLOTS; i++) begin
              held_key_nxt[i] = 8'h00;
            end
            cur_gen_nxt  = gen_r;
            attached_nxt = (gen_r != 32'd0);
            acc_nxt      = 1'b1;
          end
          hbk_pkg::MODE_DETACH: begin
            if (attached_r && gen_r == cur_gen_r) begin
              acc_nxt   = 1'b1;
              state_nxt = ST_DMOD;
            end
          end
          hbk_pkg::MODE_REPORT: begin
            if (report_ok) begin
              acc_nxt   = 1'b1;
              state_nxt = ST_REL;
            end
          end
          default: begin
            acc_nxt = 1'b0;
          end
        endcase
      end

      ST_REL, ST_MOD, ST_PRS, ST_DMOD, ST_DKEY: begin
        // Hold while an event waits for room in the output register
        if (!emit || out_free) begin
          if (emit) begin
            out_valid_nxt    = 1'b1;
            out_is_event_nxt = 1'b1;
            out_key_nxt      = cand_key;
            out_released_nxt = cand_rel;
            out_accepted_nxt = 1'b0;
            out_last_nxt     = 1'b0;
          end
          if (last_step) begin
            idx_nxt = '0;
            unique case (state_r)
              ST_REL:  state_nxt = ST_MOD;
              ST_MOD:  state_nxt = ST_PRS;
              ST_DMOD: state_nxt = ST_DKEY;
              default: state_nxt = ST_STATUS;
            endcase
            // Commit the new report, or forget everything on detach
            if (state_r == ST_PRS) begin
              held_mod_nxt = mods_in_r;
              held_key_nxt = slot_in_r;
            end
            if (state_r == ST_DKEY) begin
              held_mod_nxt = 8'h00;
              for (int i = 0; i < hbk_pkg::NUM_SLOTS; i++) begin
                held_key_nxt[i] = 8'h00;
              end
              attached_nxt = 1'b0;
              cur_gen_nxt  = 32'd0;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_is_event_nxt = 1'b0;
          out_key_nxt      = 8'h00;
          out_released_nxt = 1'b0;
          out_accepted_nxt = acc_r;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
      held_mod_r  <= 8'h00;
      cur_gen_r   <= 32'd0;
      attached_r  <= 1'b0;
      for (int i = 0; i < hbk_pkg::NUM_SLOTS; i++) begin
        held_key_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      held_mod_r  <= held_mod_nxt;
      cur_gen_r   <= cur_gen_nxt;
      attached_r  <= attached_nxt;
      held_key_r  <= held_key_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_is_event_r <= out_is_event_nxt;
    out_key_r      <= out_key_nxt;
    out_released_r <= out_released_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_event  = out_is_event_r;
  assign out_scan_code = out_key_r[6:0];
  assign out_extended  = out_key_r[7];
  assign out_released  = out_released_r;
  assign out_accepted  = out_accepted_r;
  assign out_last      = out_last_r;

  // An accepted item always starts with the validity check
  a_take_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_CHECK)
    else $error("accepted item did not enter the check state");

  // A key event never carries an empty code, status flags or the last mark
  a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_event_r |-> out_key_r[6:0] != 7'd0 && !out_last_r && !out_accepted_r)
    else $error("malformed key event");

  // Being attached implies a nonzero generation
  a_attached_gen: assert property (@(posedge clk) disable iff (!rst_n)
    attached_r |-> cur_gen_r != 32'd0)
    else $error("attached with generation zero");

  // Error usages never reach the history
  a_history_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !held_low_usage)
    else $error("history holds an error usage");

endmodule
